// ===== src/ecpa_pkg.sv =====
// shared types, constants and field helpers for the elliptic-curve point unit
`default_nettype none
package ecpa_pkg;

	localparam int FIELD_BITS  = 61;
	localparam int SCALAR_BITS = 64;
	localparam int CNT_W       = $clog2(FIELD_BITS);
	// signed euclid coefficients stay within +-p
	localparam int COEF_W      = FIELD_BITS + 2;
	localparam int CFG_IDX_W   = 2;
	localparam logic [FIELD_BITS-1:0] MOD_MIN = FIELD_BITS'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CURVE_A = 2'd0,
		CFG_CURVE_B = 2'd1,
		CFG_MODULUS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OPC_ADD   = 2'd0,
		OPC_NEG   = 2'd1,
		OPC_SMUL  = 2'd2,
		OPC_CURVE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		FOP_ADD,
		FOP_SUB,
		FOP_MUL,
		FOP_INV,
		FOP_RED
	} fu_op_t;

	typedef enum logic [2:0] {
		FU_IDLE,
		FU_RED,
		FU_MUL,
		FU_ICHK,
		FU_DIV,
		FU_UPD,
		FU_IFIN,
		FU_DONE
	} fu_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DISP,
		ST_ADD,
		ST_FIN,
		ST_SM_LOOP,
		ST_SM_ADDR,
		ST_SM_DCALL,
		ST_SM_DBL,
		ST_CURVE,
		ST_OUT
	} top_state_t;

	typedef enum logic [3:0] {
		A_CHK,
		A_D_SQ,
		A_D_2,
		A_D_3,
		A_D_A,
		A_D_DEN,
		A_G_NUM,
		A_G_DEN,
		A_INV,
		A_LAM,
		A_LSQ,
		A_X1,
		A_X2,
		A_Y1,
		A_Y2,
		A_Y3
	} add_step_t;

	typedef enum logic [3:0] {
		D_NONE,
		D_PX,
		D_PY,
		D_QX,
		D_QY,
		D_CA,
		D_CB,
		D_NUM,
		D_DEN,
		D_LAM,
		D_T,
		D_WX,
		D_WY
	} dst_t;

	typedef struct packed {
		logic                  start;
		fu_op_t                op;
		logic [FIELD_BITS-1:0] a;
		logic [FIELD_BITS-1:0] b;
	} fu_req_t;

	typedef struct packed {
		logic                  done;
		logic [FIELD_BITS-1:0] res;
	} fu_rsp_t;

	function automatic logic [FIELD_BITS-1:0] fadd(input logic [FIELD_BITS-1:0] a,
		input logic [FIELD_BITS-1:0] b, input logic [FIELD_BITS-1:0] p);
		logic [FIELD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, p}) begin
			s = s - {1'b0, p};
		end
		return s[FIELD_BITS-1:0];
	endfunction

	function automatic logic [FIELD_BITS-1:0] fsub(input logic [FIELD_BITS-1:0] a,
		input logic [FIELD_BITS-1:0] b, input logic [FIELD_BITS-1:0] p);
		logic [FIELD_BITS-1:0] r;
		if (a >= b) begin
			r = a - b;
		end else begin
			r = a + (p - b);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/ecpa_field_unit.sv =====
// shared modular arithmetic unit: add, sub, serial multiply, reduce, euclid inverse
`default_nettype none
module ecpa_field_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  ecpa_pkg::fu_req_t            req,
	input  wire  [ecpa_pkg::FIELD_BITS-1:0]    p,
	output ecpa_pkg::fu_rsp_t                  rsp
);
	localparam int FB = ecpa_pkg::FIELD_BITS;
	localparam int CW = ecpa_pkg::COEF_W;

	ecpa_pkg::fu_state_t st_q, st_d;
	logic [FB-1:0] a_q, b_q, r_q, rem_q, g_q, aa_q, res_q;
	logic [ecpa_pkg::CNT_W-1:0] cnt_q;
	logic ph_q;
	logic [CW-1:0] x_q, y_q, acc_q;

	logic [FB:0]   red_t, red_s, div_t, div_s;
	logic          div_qb;
	logic [FB-1:0] mul_n, fin_res;
	logic [CW-1:0] acc_n, p_ext, xm, xf;

	always_comb begin
		red_t = {rem_q, a_q[cnt_q]};
		red_s = (red_t >= {1'b0, p}) ? red_t - {1'b0, p} : red_t;
		div_t = {rem_q, g_q[cnt_q]};
		div_qb = div_t >= {1'b0, aa_q};
		div_s = div_qb ? div_t - {1'b0, aa_q} : div_t;
		acc_n = {acc_q[CW-2:0], 1'b0} + (div_qb ? y_q : '0);
		if (ph_q) begin
			mul_n = b_q[cnt_q] ? ecpa_pkg::fadd(r_q, a_q, p) : r_q;
		end else begin
			mul_n = ecpa_pkg::fadd(r_q, r_q, p);
		end
		// truncating remainder, then fold negatives into range
		p_ext = CW'(p);
		xm = (x_q == p_ext || x_q == (~p_ext + 1'b1)) ? '0 : x_q;
		xf = xm[CW-1] ? xm + p_ext : xm;
		fin_res = xf[FB-1:0];
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ecpa_pkg::FU_IDLE: begin
				if (req.start) begin
					case (req.op)
						ecpa_pkg::FOP_RED: st_d = ecpa_pkg::FU_RED;
						ecpa_pkg::FOP_MUL: st_d = ecpa_pkg::FU_MUL;
						ecpa_pkg::FOP_INV: st_d = ecpa_pkg::FU_ICHK;
						default:           st_d = ecpa_pkg::FU_DONE;
					endcase
				end
			end
			ecpa_pkg::FU_RED: if (cnt_q == '0) st_d = ecpa_pkg::FU_DONE;
			ecpa_pkg::FU_MUL: if (ph_q && cnt_q == '0) st_d = ecpa_pkg::FU_DONE;
			ecpa_pkg::FU_ICHK: st_d = (aa_q == '0) ? ecpa_pkg::FU_IFIN : ecpa_pkg::FU_DIV;
			ecpa_pkg::FU_DIV: if (cnt_q == '0) st_d = ecpa_pkg::FU_UPD;
			ecpa_pkg::FU_UPD: st_d = ecpa_pkg::FU_ICHK;
			ecpa_pkg::FU_IFIN: st_d = ecpa_pkg::FU_DONE;
			ecpa_pkg::FU_DONE: st_d = ecpa_pkg::FU_IDLE;
			default: st_d = ecpa_pkg::FU_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rsp.done = (st_q == ecpa_pkg::FU_DONE);
		rsp.res  = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ecpa_pkg::FU_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ecpa_pkg::FU_IDLE: begin
				if (req.start) begin
					a_q   <= req.a;
					b_q   <= req.b;
					aa_q  <= req.a;
					g_q   <= p;
					r_q   <= '0;
					rem_q <= '0;
					ph_q  <= 1'b0;
					cnt_q <= ecpa_pkg::CNT_W'(FB - 1);
					x_q   <= '0;
					y_q   <= CW'(1);
					if (req.op == ecpa_pkg::FOP_ADD) begin
						res_q <= ecpa_pkg::fadd(req.a, req.b, p);
					end else begin
						res_q <= ecpa_pkg::fsub(req.a, req.b, p);
					end
				end
			end
			ecpa_pkg::FU_RED: begin
				rem_q <= red_s[FB-1:0];
				res_q <= red_s[FB-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			ecpa_pkg::FU_MUL: begin
				ph_q  <= ~ph_q;
				r_q   <= mul_n;
				res_q <= mul_n;
				if (ph_q) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ecpa_pkg::FU_ICHK: begin
				rem_q <= '0;
				acc_q <= '0;
				cnt_q <= ecpa_pkg::CNT_W'(FB - 1);
			end
			ecpa_pkg::FU_DIV: begin
				rem_q <= div_s[FB-1:0];
				acc_q <= acc_n;
				cnt_q <= cnt_q - 1'b1;
			end
			ecpa_pkg::FU_UPD: begin
				g_q  <= aa_q;
				aa_q <= rem_q;
				y_q  <= x_q - acc_q;
				x_q  <= y_q;
			end
			ecpa_pkg::FU_IFIN: res_q <= fin_res;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/ec_point_arith_scalar_mul.sv =====
// top level of the affine elliptic-curve point unit
`default_nettype none
// Affine point unit for y^2 = x^3 + a*x + b over GF(p). The user must set a, b and p
// through the write port only while the block is idle; the block itself does not
// enforce this (a modulus below 3 acts as 3). One request at a time: in_stall is
// high from acceptance until the result is loaded into the output register, which
// then waits for the sink while the next request is taken. All field arithmetic
// but the negation of y runs through one shared field unit under the sequencer
// below. Field add and sub are formed when the request is taken, reduction and
// multiply are bit-serial, and an inverse iterates euclid quotient steps (up to
// roughly 90 steps for a 61-bit prime), so it dominates a point add or double. A
// scalar multiply does up to 2*64 point operations; negate and the on-curve test
// (six field ops, then a compare) follow input reduction.
module ec_point_arith_scalar_mul (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// configuration
	input  wire                                    cfg_we,
	input  wire  [ecpa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [ecpa_pkg::FIELD_BITS-1:0]        cfg_data,
	// request channel
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire  [1:0]                             opcode,
	input  wire  [ecpa_pkg::FIELD_BITS-1:0]        first_x,
	input  wire  [ecpa_pkg::FIELD_BITS-1:0]        first_y,
	input  wire                                    first_inf,
	input  wire  [ecpa_pkg::FIELD_BITS-1:0]        second_x,
	input  wire  [ecpa_pkg::FIELD_BITS-1:0]        second_y,
	input  wire                                    second_inf,
	input  wire signed [ecpa_pkg::SCALAR_BITS-1:0] scalar,
	// result channel
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output logic [ecpa_pkg::FIELD_BITS-1:0]        result_x,
	output logic [ecpa_pkg::FIELD_BITS-1:0]        result_y,
	output logic                                   result_inf,
	output logic                                   on_curve
);
	localparam int FB = ecpa_pkg::FIELD_BITS;
	localparam int SB = ecpa_pkg::SCALAR_BITS;
	// input reduction walks six operands, on-curve test six field ops then a compare
	localparam logic [2:0] LOAD_LAST = 3'd5;
	localparam logic [2:0] OC_CMP    = 3'd6;

	// configuration registers
	logic [FB-1:0] curve_a_q, curve_b_q, modulus_q, p_eff;

	// sequencer
	ecpa_pkg::top_state_t st_q, st_d, ret_q;
	ecpa_pkg::add_step_t  as_q, as_d;
	logic [2:0]           cnt_q, cnt_d;
	logic                 wait_q;

	// request and working registers
	ecpa_pkg::opcode_t opc_q;
	logic [FB-1:0] px_q, py_q, qx_q, qy_q, ca_q, cb_q;
	logic          pinf_q, qinf_q;
	logic [SB-1:0] scalar_q, mag_q, mag_d;
	logic [FB-1:0] rx_q, ry_q, bx_q, by_q, ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;
	logic          rinf_q, uinf_q, vinf_q, winf_q, on_q;
	logic [FB-1:0] num_q, den_q, lam_q, t_q;

	// field unit hookup
	ecpa_pkg::fu_req_t fu_req;
	ecpa_pkg::fu_rsp_t fu_rsp;
	ecpa_pkg::fu_op_t  uop;
	logic [FB-1:0]     opa, opb;
	ecpa_pkg::dst_t    dst;
	logic              is_call;

	logic in_acc, out_load, add_eq, scal_neg;
	logic [FB-1:0] py_neg;

	assign p_eff    = (modulus_q < ecpa_pkg::MOD_MIN) ? ecpa_pkg::MOD_MIN : modulus_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (st_q == ecpa_pkg::ST_OUT) && (!out_valid || !out_stall);
	assign add_eq   = (ux_q == vx_q) && (uy_q == vy_q);
	assign scal_neg = scalar_q[SB-1];
	// two's complement magnitude; the most negative value maps onto itself
	assign mag_d    = scal_neg ? (~scalar_q + 1'b1) : scalar_q;
	assign py_neg   = ecpa_pkg::fsub('0, py_q, p_eff);

	ecpa_field_unit u_fu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fu_req),
		.p      (p_eff),
		.rsp    (fu_rsp)
	);

	// micro-op table: field op, operands and destination for the current step
	always_comb begin
		uop     = ecpa_pkg::FOP_ADD;
		opa     = '0;
		opb     = '0;
		dst     = ecpa_pkg::D_NONE;
		is_call = 1'b0;
		case (st_q)
			ecpa_pkg::ST_LOAD: begin
				is_call = 1'b1;
				uop     = ecpa_pkg::FOP_RED;
				case (cnt_q)
					3'd0:    begin opa = px_q;      dst = ecpa_pkg::D_PX; end
					3'd1:    begin opa = py_q;      dst = ecpa_pkg::D_PY; end
					3'd2:    begin opa = qx_q;      dst = ecpa_pkg::D_QX; end
					3'd3:    begin opa = qy_q;      dst = ecpa_pkg::D_QY; end
					3'd4:    begin opa = curve_a_q; dst = ecpa_pkg::D_CA; end
					default: begin opa = curve_b_q; dst = ecpa_pkg::D_CB; end
				endcase
			end
			ecpa_pkg::ST_ADD: begin
				is_call = (as_q != ecpa_pkg::A_CHK);
				case (as_q)
					// tangent: 3x^2 + a over 2y
					ecpa_pkg::A_D_SQ: begin
						uop = ecpa_pkg::FOP_MUL; opa = ux_q; opb = ux_q; dst = ecpa_pkg::D_NUM;
					end
					ecpa_pkg::A_D_2: begin
						opa = num_q; opb = num_q; dst = ecpa_pkg::D_T;
					end
					ecpa_pkg::A_D_3: begin
						opa = t_q; opb = num_q; dst = ecpa_pkg::D_T;
					end
					ecpa_pkg::A_D_A: begin
						opa = t_q; opb = ca_q; dst = ecpa_pkg::D_NUM;
					end
					ecpa_pkg::A_D_DEN: begin
						opa = uy_q; opb = uy_q; dst = ecpa_pkg::D_DEN;
					end
					// chord: (y2 - y1) over (x2 - x1)
					ecpa_pkg::A_G_NUM: begin
						uop = ecpa_pkg::FOP_SUB; opa = vy_q; opb = uy_q; dst = ecpa_pkg::D_NUM;
					end
					ecpa_pkg::A_G_DEN: begin
						uop = ecpa_pkg::FOP_SUB; opa = vx_q; opb = ux_q; dst = ecpa_pkg::D_DEN;
					end
					ecpa_pkg::A_INV: begin
						uop = ecpa_pkg::FOP_INV; opa = den_q; dst = ecpa_pkg::D_T;
					end
					ecpa_pkg::A_LAM: begin
						uop = ecpa_pkg::FOP_MUL; opa = num_q; opb = t_q; dst = ecpa_pkg::D_LAM;
					end
					ecpa_pkg::A_LSQ: begin
						uop = ecpa_pkg::FOP_MUL; opa = lam_q; opb = lam_q; dst = ecpa_pkg::D_T;
					end
					ecpa_pkg::A_X1: begin
						uop = ecpa_pkg::FOP_SUB; opa = t_q; opb = ux_q; dst = ecpa_pkg::D_T;
					end
					ecpa_pkg::A_X2: begin
						uop = ecpa_pkg::FOP_SUB; opa = t_q; opb = vx_q; dst = ecpa_pkg::D_WX;
					end
					ecpa_pkg::A_Y1: begin
						uop = ecpa_pkg::FOP_SUB; opa = ux_q; opb = wx_q; dst = ecpa_pkg::D_T;
					end
					ecpa_pkg::A_Y2: begin
						uop = ecpa_pkg::FOP_MUL; opa = lam_q; opb = t_q; dst = ecpa_pkg::D_T;
					end
					ecpa_pkg::A_Y3: begin
						uop = ecpa_pkg::FOP_SUB; opa = t_q; opb = uy_q; dst = ecpa_pkg::D_WY;
					end
					default: ;
				endcase
			end
			ecpa_pkg::ST_CURVE: begin
				is_call = (cnt_q != OC_CMP);
				case (cnt_q)
					3'd0: begin
						uop = ecpa_pkg::FOP_MUL; opa = py_q; opb = py_q; dst = ecpa_pkg::D_NUM;
					end
					3'd1: begin
						uop = ecpa_pkg::FOP_MUL; opa = px_q; opb = px_q; dst = ecpa_pkg::D_T;
					end
					3'd2: begin
						uop = ecpa_pkg::FOP_MUL; opa = px_q; opb = t_q; dst = ecpa_pkg::D_T;
					end
					3'd3: begin
						uop = ecpa_pkg::FOP_MUL; opa = ca_q; opb = px_q; dst = ecpa_pkg::D_LAM;
					end
					3'd4: begin
						opa = t_q; opb = lam_q; dst = ecpa_pkg::D_T;
					end
					3'd5: begin
						opa = t_q; opb = cb_q; dst = ecpa_pkg::D_T;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		st_d  = st_q;
		as_d  = as_q;
		cnt_d = cnt_q;
		case (st_q)
			ecpa_pkg::ST_IDLE: begin
				if (in_valid) begin
					st_d  = ecpa_pkg::ST_LOAD;
					cnt_d = '0;
				end
			end
			ecpa_pkg::ST_LOAD: begin
				if (fu_rsp.done) begin
					if (cnt_q == LOAD_LAST) begin
						st_d = ecpa_pkg::ST_DISP;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			ecpa_pkg::ST_DISP: begin
				as_d  = ecpa_pkg::A_CHK;
				cnt_d = '0;
				case (opc_q)
					ecpa_pkg::OPC_ADD:  st_d = ecpa_pkg::ST_ADD;
					ecpa_pkg::OPC_NEG:  st_d = ecpa_pkg::ST_OUT;
					ecpa_pkg::OPC_SMUL: begin
						st_d = (pinf_q || mag_d == '0) ? ecpa_pkg::ST_OUT : ecpa_pkg::ST_SM_LOOP;
					end
					default: st_d = pinf_q ? ecpa_pkg::ST_OUT : ecpa_pkg::ST_CURVE;
				endcase
			end
			ecpa_pkg::ST_ADD: begin
				if (as_q == ecpa_pkg::A_CHK) begin
					if (uinf_q || vinf_q || (add_eq && uy_q == '0)) begin
						st_d = ret_q;
					end else if (add_eq) begin
						as_d = ecpa_pkg::A_D_SQ;
					end else if (ux_q == vx_q) begin
						// p + (-p)
						st_d = ret_q;
					end else begin
						as_d = ecpa_pkg::A_G_NUM;
					end
				end else if (fu_rsp.done) begin
					case (as_q)
						ecpa_pkg::A_D_DEN: as_d = ecpa_pkg::A_INV;
						ecpa_pkg::A_Y3:    st_d = ret_q;
						default:           as_d = ecpa_pkg::add_step_t'(as_q + 1'b1);
					endcase
				end
			end
			ecpa_pkg::ST_FIN: st_d = ecpa_pkg::ST_OUT;
			ecpa_pkg::ST_SM_LOOP: begin
				as_d = ecpa_pkg::A_CHK;
				if (mag_q == '0) begin
					st_d = ecpa_pkg::ST_OUT;
				end else if (mag_q[0]) begin
					st_d = ecpa_pkg::ST_ADD;
				end else begin
					st_d = ecpa_pkg::ST_SM_DCALL;
				end
			end
			ecpa_pkg::ST_SM_ADDR: st_d = ecpa_pkg::ST_SM_DCALL;
			ecpa_pkg::ST_SM_DCALL: begin
				as_d = ecpa_pkg::A_CHK;
				st_d = ecpa_pkg::ST_ADD;
			end
			ecpa_pkg::ST_SM_DBL: begin
				// doubling to infinity ends the loop early
				st_d = winf_q ? ecpa_pkg::ST_OUT : ecpa_pkg::ST_SM_LOOP;
			end
			ecpa_pkg::ST_CURVE: begin
				if (cnt_q == OC_CMP) begin
					st_d = ecpa_pkg::ST_OUT;
				end else if (fu_rsp.done) begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ecpa_pkg::ST_OUT: if (out_load) st_d = ecpa_pkg::ST_IDLE;
			default: st_d = ecpa_pkg::ST_IDLE;
		endcase
	end

	// outputs and field unit request
	always_comb begin
		in_stall     = (st_q != ecpa_pkg::ST_IDLE);
		fu_req.start = is_call && !wait_q;
		fu_req.op    = uop;
		fu_req.a     = opa;
		fu_req.b     = opb;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ecpa_pkg::ST_IDLE;
			as_q      <= ecpa_pkg::A_CHK;
			cnt_q     <= '0;
			wait_q    <= 1'b0;
			out_valid <= 1'b0;
			curve_a_q <= FB'(1);
			curve_b_q <= FB'(1);
			modulus_q <= FB'(3);
		end else begin
			st_q  <= st_d;
			as_q  <= as_d;
			cnt_q <= cnt_d;
			if (fu_rsp.done) begin
				wait_q <= 1'b0;
			end else if (fu_req.start) begin
				wait_q <= 1'b1;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					ecpa_pkg::CFG_CURVE_A: curve_a_q <= cfg_data;
					ecpa_pkg::CFG_CURVE_B: curve_b_q <= cfg_data;
					ecpa_pkg::CFG_MODULUS: modulus_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			opc_q    <= ecpa_pkg::opcode_t'(opcode);
			px_q     <= first_x;
			py_q     <= first_y;
			pinf_q   <= first_inf;
			qx_q     <= second_x;
			qy_q     <= second_y;
			qinf_q   <= second_inf;
			scalar_q <= scalar;
		end

		// field unit write-back
		if (fu_rsp.done) begin
			case (dst)
				ecpa_pkg::D_PX:  px_q  <= fu_rsp.res;
				ecpa_pkg::D_PY:  py_q  <= fu_rsp.res;
				ecpa_pkg::D_QX:  qx_q  <= fu_rsp.res;
				ecpa_pkg::D_QY:  qy_q  <= fu_rsp.res;
				ecpa_pkg::D_CA:  ca_q  <= fu_rsp.res;
				ecpa_pkg::D_CB:  cb_q  <= fu_rsp.res;
				ecpa_pkg::D_NUM: num_q <= fu_rsp.res;
				ecpa_pkg::D_DEN: den_q <= fu_rsp.res;
				ecpa_pkg::D_LAM: lam_q <= fu_rsp.res;
				ecpa_pkg::D_T:   t_q   <= fu_rsp.res;
				ecpa_pkg::D_WX:  wx_q  <= fu_rsp.res;
				ecpa_pkg::D_WY: begin
					wy_q   <= fu_rsp.res;
					winf_q <= 1'b0;
				end
				default: ;
			endcase
		end

		case (st_q)
			ecpa_pkg::ST_DISP: begin
				on_q   <= (opc_q == ecpa_pkg::OPC_CURVE) && pinf_q;
				ux_q   <= px_q;
				uy_q   <= py_q;
				uinf_q <= pinf_q;
				vx_q   <= qx_q;
				vy_q   <= qy_q;
				vinf_q <= qinf_q;
				ret_q  <= ecpa_pkg::ST_FIN;
				mag_q  <= mag_d;
				bx_q   <= px_q;
				by_q   <= scal_neg ? py_neg : py_q;
				case (opc_q)
					ecpa_pkg::OPC_NEG: begin
						rinf_q <= pinf_q;
						rx_q   <= px_q;
						ry_q   <= py_neg;
					end
					ecpa_pkg::OPC_CURVE: begin
						rinf_q <= 1'b0;
						rx_q   <= '0;
						ry_q   <= '0;
					end
					default: rinf_q <= 1'b1;
				endcase
			end
			ecpa_pkg::ST_ADD: begin
				if (as_q == ecpa_pkg::A_CHK) begin
					if (uinf_q) begin
						wx_q   <= vx_q;
						wy_q   <= vy_q;
						winf_q <= vinf_q;
					end else if (vinf_q) begin
						wx_q   <= ux_q;
						wy_q   <= uy_q;
						winf_q <= 1'b0;
					end else begin
						winf_q <= 1'b1;
					end
				end
			end
			ecpa_pkg::ST_FIN, ecpa_pkg::ST_SM_ADDR: begin
				rx_q   <= wx_q;
				ry_q   <= wy_q;
				rinf_q <= winf_q;
			end
			ecpa_pkg::ST_SM_LOOP: begin
				// accumulator plus base on a set bit
				ux_q   <= rx_q;
				uy_q   <= ry_q;
				uinf_q <= rinf_q;
				vx_q   <= bx_q;
				vy_q   <= by_q;
				vinf_q <= 1'b0;
				ret_q  <= ecpa_pkg::ST_SM_ADDR;
			end
			ecpa_pkg::ST_SM_DCALL: begin
				ux_q   <= bx_q;
				uy_q   <= by_q;
				uinf_q <= 1'b0;
				vx_q   <= bx_q;
				vy_q   <= by_q;
				vinf_q <= 1'b0;
				ret_q  <= ecpa_pkg::ST_SM_DBL;
			end
			ecpa_pkg::ST_SM_DBL: begin
				if (!winf_q) begin
					bx_q  <= wx_q;
					by_q  <= wy_q;
					mag_q <= mag_q >> 1;
				end
			end
			ecpa_pkg::ST_CURVE: begin
				if (cnt_q == OC_CMP) begin
					on_q <= (num_q == t_q);
				end
			end
			default: ;
		endcase

		if (out_load) begin
			result_x   <= rinf_q ? '0 : rx_q;
			result_y   <= rinf_q ? '0 : ry_q;
			result_inf <= rinf_q;
			on_curve   <= on_q;
		end
	end
endmodule
`default_nettype wire
